@@ src/bff_pkg.sv @@
// Shared types and constants for the bloom filter engine.
`timescale 1ns / 1ps
`default_nettype none
package bff_pkg;

    localparam int unsigned MAX_BITS_DEF   = 65536;
    localparam int unsigned MAX_HASHES_DEF = 16;

    localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam int unsigned FNV_SHIFT   = 40;       // prime = 2^40 + FNV_LOW
    localparam logic [8:0]  FNV_LOW     = 9'h1b3;

    localparam int unsigned ROW_W       = 64;       // store row width in bits
    localparam int unsigned ROW_SH      = 6;        // log2 of ROW_W

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_HASH_COUNT  = 1'b0;
    localparam logic REG_FILTER_BITS = 1'b1;

    localparam logic [4:0]  HASH_COUNT_RST  = 5'd7;
    localparam logic [16:0] FILTER_BITS_RST = 17'd65536;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_DIV_LOAD,
        ST_DIV,
        ST_RD,
        ST_UPD,
        ST_RESULT
    } bff_state_t;

    typedef struct packed {
        logic capture;
        logic lane_clr;
        logic lane_inc;
        logic hash_en;
        logic lanes_restart;
        logic all_clr;
        logic div_load;
        logic div_step;
        logic rd_issue;
        logic wr_set;
        logic chk_en;
        logic row_clr;
        logic row_wipe;
        logic out_load;
    } bff_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_cmd;
        logic       lane_end;
        logic       probe_end;
        logic       div_done;
        logic       row_end;
        logic       key_last;
        logic [1:0] key_cmd;
        logic       out_free;
    } bff_sts_t;

endpackage
`default_nettype wire

@@ src/bff_ctrl.sv @@
// Sequencer for the bloom filter engine: hashing, probe and clear control.
`timescale 1ns / 1ps
`default_nettype none
module bff_ctrl
    import bff_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire bff_sts_t sts,
    output bff_cmd_t      cmd,
    output logic          in_ready
);

    bff_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.row_end) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (sts.in_valid) begin
                    if (sts.in_cmd == CMD_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (sts.in_cmd == CMD_ADD || sts.in_cmd == CMD_QUERY) begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (sts.lane_end) state_next = sts.key_last ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (sts.div_done) state_next = ST_RD;
            end
            ST_RD: state_next = ST_UPD;
            ST_UPD: begin
                if (!sts.probe_end) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    state_next = (sts.key_cmd == CMD_QUERY) ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.row_wipe = 1'b1;
            end
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = sts.in_valid;
                cmd.lane_clr = sts.in_valid;
                if (sts.in_valid && sts.in_cmd == CMD_CLEAR) begin
                    cmd.lanes_restart = 1'b1;
                    cmd.row_clr       = 1'b1;
                end
            end
            ST_HASH: begin
                cmd.hash_en  = 1'b1;
                cmd.lane_inc = !sts.lane_end;
                cmd.lane_clr = sts.lane_end;
                cmd.all_clr  = sts.lane_end;
            end
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_RD:       cmd.rd_issue = 1'b1;
            ST_UPD: begin
                cmd.wr_set        = (sts.key_cmd == CMD_ADD);
                cmd.chk_en        = (sts.key_cmd == CMD_QUERY);
                cmd.lane_inc      = !sts.probe_end;
                cmd.lanes_restart = sts.probe_end;
            end
            ST_RESULT: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

    // a result is only ever loaded into a free output slot
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending word");
    // the divider runs only for keys that end
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> sts.key_last)
        else $error("probe started on a non-final byte");
    // a clear command always enters the wipe
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_clr |=> state_reg == ST_CLEAR)
        else $error("clear did not start the wipe");

endmodule
`default_nettype wire

@@ src/bff_datapath.sv @@
// Hash lanes, remainder unit, bit store, configuration and output register.
`timescale 1ns / 1ps
`default_nettype none
module bff_datapath
    import bff_pkg::*;
#(
    parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire bff_cmd_t    cmd,
    output bff_sts_t         sts,
    input  wire logic        s_tvalid,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int unsigned LANE_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int unsigned FB_W   = $clog2(MAX_BITS + 1);
    localparam int unsigned R_W    = FB_W + 1;
    localparam int unsigned CMP_W  = (FB_W > 17) ? FB_W : 17;
    localparam int unsigned ROWS   = MAX_BITS / ROW_W;
    localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // configuration
    logic [4:0]  hash_count_reg;
    logic [16:0] filter_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_count_reg  <= HASH_COUNT_RST;
            filter_bits_reg <= FILTER_BITS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_HASH_COUNT) hash_count_reg <= cfg_data[4:0];
            else                             hash_count_reg <= hash_count_reg;
            if (cfg_index == REG_FILTER_BITS) filter_bits_reg <= cfg_data;
        end
    end

    // clamped probe count and divisor
    logic [6:0]       hc_used;
    logic [CMP_W-1:0] fb_wide;
    logic [R_W-1:0]   fb_eff;

    always_comb begin
        if (hash_count_reg == 5'd0)                     hc_used = 7'd1;
        else if (7'(hash_count_reg) > 7'(MAX_HASHES))   hc_used = 7'(MAX_HASHES);
        else                                            hc_used = 7'(hash_count_reg);
        fb_wide = CMP_W'(filter_bits_reg);
        if (fb_wide < CMP_W'(64))            fb_wide = CMP_W'(64);
        else if (fb_wide > CMP_W'(MAX_BITS)) fb_wide = CMP_W'(MAX_BITS);
        fb_eff = R_W'(fb_wide);
    end

    // captured input word
    logic       key_last_reg;
    logic [1:0] key_cmd_reg;
    logic [7:0] key_byte_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_last_reg <= s_tlast;
            key_cmd_reg  <= s_tuser;
            key_byte_reg <= s_tdata;
        end
    end

    // hash lanes, one lane updated per cycle
    logic [63:0]       lanes_reg [MAX_HASHES];
    logic [LANE_W-1:0] lane_reg;
    logic [63:0]       mix;
    logic [63:0]       mul_next;

    always_comb begin
        mix      = lanes_reg[lane_reg] ^ 64'(key_byte_reg);
        mul_next = (mix << FNV_SHIFT) + (mix * 64'(FNV_LOW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.lanes_restart) begin
            for (int i = 0; i < MAX_HASHES; i++) lanes_reg[i] <= FNV_BASIS ^ 64'(i);
        end else if (cmd.hash_en) begin
            lanes_reg[lane_reg] <= mul_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.lane_clr) lane_reg <= '0;
        else if (cmd.lane_inc)        lane_reg <= lane_reg + 1'b1;
    end

    // restoring remainder, one dividend bit per cycle
    logic [63:0]    div_reg;
    logic [5:0]     div_cnt_reg;
    logic [R_W-1:0] rem_reg;
    logic [R_W-1:0] rem_try;

    assign rem_try = {rem_reg[R_W-2:0], div_reg[63]};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            div_reg     <= lanes_reg[lane_reg];
            div_cnt_reg <= 6'd63;
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            div_reg     <= div_reg << 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
            rem_reg     <= (rem_try >= fb_eff) ? rem_try - fb_eff : rem_try;
        end
    end

    // bit store, 64-bit rows, registered read
    logic [ROW_W-1:0]  store_mem [ROWS];
    logic [ROW_W-1:0]  rd_row_reg;
    logic [ROW_AW-1:0] addr_reg;
    logic [ROW_SH-1:0] bit_reg;
    logic [ROW_AW-1:0] wipe_reg;
    logic              all_set_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_row_reg <= store_mem[ROW_AW'(rem_reg >> ROW_SH)];
            addr_reg   <= ROW_AW'(rem_reg >> ROW_SH);
            bit_reg    <= rem_reg[ROW_SH-1:0];
        end
        if (cmd.row_wipe) begin
            store_mem[wipe_reg] <= '0;
        end else if (cmd.wr_set) begin
            store_mem[addr_reg] <= rd_row_reg | (ROW_W'(1) << bit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.row_clr) wipe_reg <= '0;
        else if (cmd.row_wipe)       wipe_reg <= wipe_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.all_clr)     all_set_reg <= 1'b1;
        else if (cmd.chk_en) all_set_reg <= all_set_reg & rd_row_reg[bit_reg];
    end

    // output register
    logic m_valid_reg;
    logic m_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_bit_reg <= all_set_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_bit_reg};

    always_comb begin
        sts.in_valid  = s_tvalid;
        sts.in_cmd    = s_tuser;
        sts.lane_end  = (lane_reg == LANE_W'(MAX_HASHES - 1));
        sts.probe_end = (7'(lane_reg) == hc_used - 7'd1);
        sts.div_done  = (div_cnt_reg == 6'd0);
        sts.row_end   = (wipe_reg == ROW_AW'(ROWS - 1));
        sts.key_last  = key_last_reg;
        sts.key_cmd   = key_cmd_reg;
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // every divide starts from a full 64-bit count
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.div_load) |-> div_cnt_reg == 6'd63)
        else $error("divider count not loaded");
    // the partial remainder never reaches the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.div_step) |-> rem_reg < fb_eff)
        else $error("remainder out of range");
    // lane zero holds the offset basis right after a restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lanes_restart |=> lanes_reg[0] == FNV_BASIS)
        else $error("lane restart failed");

endmodule
`default_nettype wire

@@ src/bloom_filter_fnv1a_core.sv @@
// Top level of the bloom filter engine: FNV-1a 64 lanes over a one-bit store.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata key_byte, s_tuser command, s_tlast last
//  m_        out  m_tvalid/m_tready    m_tdata[0] maybe_present
//  cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A key word is accepted and then hashed in the single lane multiplier across all
// MAX_HASHES lanes (one lane per cycle). Each probe of a final word then runs a reload,
// the bit-serial remainder, a store read and an update.
// After the last probe a query loads its result once the output register is free;
// the result sits in the output register and the next word is taken while it waits.
// After reset, and after a clear word, the store is wiped one 64-bit row a cycle,
// MAX_BITS/64 rows (1024 at the default), with s_tready low throughout.
// Configuration words are taken every cycle; write them only while idle.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_fnv1a_core
    import bff_pkg::*;
#(
    parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] key_byte
    input  wire logic [1:0]  s_tuser,    // [1:0] command
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [0] maybe_present, rest zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,  // 0 hash_count, 1 filter_bits
    input  wire logic [16:0] cfg_data
);

    bff_cmd_t cmd;
    bff_sts_t sts;

    assign cfg_ready = 1'b1;

    bff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    bff_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
